// File: rtl/cod_pkg.sv
// ----------------------------------------------------------------------------
// cod_pkg
// Shared types and constants of the CMYK ordered-dither row halftoner.
// ----------------------------------------------------------------------------
package cod_pkg;

    localparam int COL_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int REP_W   = 5;
    localparam int CFG_W   = 64;
    localparam int Q_DEPTH = 2;

    localparam logic [3:0] THRESH_FLIP = 4'hF;

    typedef enum logic [1:0] {
        CFG_THRESHOLD_LEVEL  = 2'd0,
        CFG_GREYSCALE_MODE   = 2'd1,
        CFG_DITHER_ROWS_LOW  = 2'd2,
        CFG_DITHER_ROWS_HIGH = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_BEGIN_ROW = 1'b0,
        CMD_PIXEL     = 1'b1
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [3:0]       threshold_level;
        logic             greyscale_mode;
        logic [CFG_W-1:0] dither_rows_low;
        logic [CFG_W-1:0] dither_rows_high;
    } cfg_t;

    // rep_last holds the clamped repeat count minus one
    typedef struct packed {
        cmd_t               cmd;
        logic [1:0]         phase;
        logic [COL_W-1:0]   column;
        logic [LEVEL_W-1:0] black;
        logic [LEVEL_W-1:0] yellow;
        logic [LEVEL_W-1:0] magenta;
        logic [LEVEL_W-1:0] cyan;
        logic [REP_W-1:0]   rep_last;
        logic               eor;
    } entry_t;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic             black;
        logic             yellow;
        logic             magenta;
        logic             cyan;
        logic             last_of_pixel;
        logic             row_done;
    } dot_t;

endpackage

// File: rtl/cmyk_ordered_dither_row.sv
// ----------------------------------------------------------------------------
// cmyk_ordered_dither_row
// Halftones one printer row with a 4x4 ordered dither in CMYK.
// ----------------------------------------------------------------------------
//   channel  dir  handshake         payload
//   s_       in   s_valid/s_ready   cmd, row, start column, CMYK, repeat, eor
//   m_       out  m_valid/m_ready   dot column, four plane bits, last, row done
//   cfg_     in   cfg_wr_en         cfg_index, cfg_wdata
//
// A source pixel is dequeued and then expanded into its dots, where the dot
// count is repeat_count with zero taken as one and clamped to MAX_REPEAT; a
// begin-row word is only dequeued. The dot engine is the limit. A two-entry
// queue sits between input stage and dot engine. aresetn is synchronous,
// active low, and clears control state and configuration; data registers are
// not reset. Output stalls hold the current dot.
// ----------------------------------------------------------------------------
module cmyk_ordered_dither_row #(
    parameter int MAX_REPEAT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [15:0] s_row_number,
    input  logic [15:0] s_start_column,
    input  logic [7:0]  s_black_level,
    input  logic [7:0]  s_yellow_level,
    input  logic [7:0]  s_magenta_level,
    input  logic [7:0]  s_cyan_level,
    input  logic [4:0]  s_repeat_count,
    input  logic        s_end_of_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_dot_column,
    output logic        m_black_dot,
    output logic        m_yellow_dot,
    output logic        m_magenta_dot,
    output logic        m_cyan_dot,
    output logic        m_last_of_pixel,
    output logic        m_row_done
);
    import cod_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   push_valid, push_ready;
    entry_t push_data;
    logic   q_valid, q_pop;
    entry_t q_data;
    dot_t   dot;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_THRESHOLD_LEVEL:  cfg_next.threshold_level  = cfg_wdata[3:0];
                CFG_GREYSCALE_MODE:   cfg_next.greyscale_mode   = cfg_wdata[0];
                CFG_DITHER_ROWS_LOW:  cfg_next.dither_rows_low  = cfg_wdata;
                CFG_DITHER_ROWS_HIGH: cfg_next.dither_rows_high = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cod_front #(
        .MAX_REPEAT (MAX_REPEAT)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_row_number    (s_row_number),
        .s_start_column  (s_start_column),
        .s_black_level   (s_black_level),
        .s_yellow_level  (s_yellow_level),
        .s_magenta_level (s_magenta_level),
        .s_cyan_level    (s_cyan_level),
        .s_repeat_count  (s_repeat_count),
        .s_end_of_row    (s_end_of_row),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_data       (push_data)
    );

    cod_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    cod_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_dot   (dot)
    );

    assign m_dot_column    = dot.column;
    assign m_black_dot     = dot.black;
    assign m_yellow_dot    = dot.yellow;
    assign m_magenta_dot   = dot.magenta;
    assign m_cyan_dot      = dot.cyan;
    assign m_last_of_pixel = dot.last_of_pixel;
    assign m_row_done      = dot.row_done;

endmodule

// File: rtl/cod_front.sv
// ----------------------------------------------------------------------------
// cod_front
// Input stage: takes words, clamps the repeat count and forwards an entry.
// ----------------------------------------------------------------------------
module cod_front #(
    parameter int MAX_REPEAT = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_cmd,
    input  logic [15:0]                s_row_number,
    input  logic [15:0]                s_start_column,
    input  logic [7:0]                 s_black_level,
    input  logic [7:0]                 s_yellow_level,
    input  logic [7:0]                 s_magenta_level,
    input  logic [7:0]                 s_cyan_level,
    input  logic [4:0]                 s_repeat_count,
    input  logic                       s_end_of_row,
    output logic                       push_valid,
    input  logic                       push_ready,
    output cod_pkg::entry_t            push_data
);
    import cod_pkg::*;

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;
    logic   s_accept;

    assign s_ready  = !valid_reg || push_ready;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        entry_next.cmd     = cmd_t'(s_cmd);
        entry_next.phase   = s_row_number[1:0];
        entry_next.column  = s_start_column;
        entry_next.black   = s_black_level;
        entry_next.yellow  = s_yellow_level;
        entry_next.magenta = s_magenta_level;
        entry_next.cyan    = s_cyan_level;
        entry_next.eor     = s_end_of_row;
        if (s_repeat_count == '0) begin
            entry_next.rep_last = '0;
        end else if (int'(s_repeat_count) > MAX_REPEAT) begin
            entry_next.rep_last = REP_W'(MAX_REPEAT - 1);
        end else begin
            entry_next.rep_last = s_repeat_count - REP_W'(1);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_accept) begin
            entry_reg <= entry_next;
        end
    end

    assign push_valid = valid_reg;
    assign push_data  = entry_reg;

endmodule

// File: rtl/cod_queue.sv
// ----------------------------------------------------------------------------
// cod_queue
// Short register queue between the input stage and the dot engine.
// ----------------------------------------------------------------------------
module cod_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  cod_pkg::entry_t push_data,
    output logic            pop_valid,
    input  logic            pop,
    output cod_pkg::entry_t pop_data
);
    import cod_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    entry_t             mem_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(Q_DEPTH))
        else $error("queue count above depth");

endmodule

// File: rtl/cod_back.sv
// ----------------------------------------------------------------------------
// cod_back
// Dot engine: applies begin-row entries and expands pixels into dots.
// ----------------------------------------------------------------------------
module cod_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  cod_pkg::cfg_t   cfg,
    input  logic            q_valid,
    output logic            q_pop,
    input  cod_pkg::entry_t q_data,
    output logic            m_valid,
    input  logic            m_ready,
    output cod_pkg::dot_t   m_dot
);
    import cod_pkg::*;

    back_state_t        state_reg, state_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [1:0]         phase_reg, phase_next;
    logic [REP_W-1:0]   cnt_reg, cnt_next;
    entry_t             pix_reg;
    dot_t               dot_reg, dot_next;
    logic               m_valid_reg, m_valid_next;
    logic               fire, load_row, load_pixel;
    logic [3:0]         entry_idx;
    logic [CFG_W-1:0]   dither_word;
    logic [7:0]         dither_val;
    logic [7:0]         thresh_val;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_data.cmd == CMD_PIXEL) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (fire && cnt_reg == '0) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop = 1'b0;
        fire  = 1'b0;
        unique case (state_reg)
            ST_IDLE: q_pop = q_valid;
            ST_RUN:  fire  = !m_valid_reg || m_ready;
            default: begin
                q_pop = 1'b0;
                fire  = 1'b0;
            end
        endcase
    end

    assign load_row   = q_pop && q_data.cmd == CMD_BEGIN_ROW;
    assign load_pixel = q_pop && q_data.cmd == CMD_PIXEL;

    assign entry_idx   = {phase_reg, col_reg[1:0]};
    assign dither_word = entry_idx[3] ? cfg.dither_rows_high : cfg.dither_rows_low;
    assign dither_val  = dither_word[{entry_idx[2:0], 3'b000} +: 8];
    assign thresh_val  = {4'b0000, cfg.threshold_level ^ THRESH_FLIP};

    always_comb begin
        dot_next               = '0;
        dot_next.column        = col_reg;
        dot_next.last_of_pixel = (cnt_reg == '0);
        dot_next.row_done      = (cnt_reg == '0) && pix_reg.eor;
        if (cfg.threshold_level != '0) begin
            dot_next.black = pix_reg.black > thresh_val;
        end else if (cfg.greyscale_mode) begin
            dot_next.black = pix_reg.black > dither_val;
        end else if (pix_reg.black > dither_val) begin
            dot_next.black = 1'b1;
        end else begin
            dot_next.yellow  = pix_reg.yellow > dither_val;
            dot_next.magenta = pix_reg.magenta > dither_val;
            dot_next.cyan    = pix_reg.cyan > dither_val;
        end
    end

    always_comb begin
        col_next     = col_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_row) begin
            col_next   = q_data.column;
            phase_next = q_data.phase;
        end
        if (load_pixel) begin
            cnt_next = q_data.rep_last;
        end
        if (fire) begin
            col_next     = col_reg + COL_W'(1);
            cnt_next     = cnt_reg - REP_W'(1);
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            phase_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        if (load_pixel) begin
            pix_reg <= q_data;
        end
        if (fire) begin
            dot_reg <= dot_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_dot   = dot_reg;

    a_row_load: assert property (@(posedge aclk) disable iff (!aresetn)
        load_row |=> col_reg == $past(q_data.column) && phase_reg == $past(q_data.phase))
        else $error("begin-row entry not applied");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && cnt_reg == '0 |=> state_reg == ST_IDLE && m_dot.last_of_pixel)
        else $error("pixel did not end on its last dot");

    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> col_reg == $past(col_reg) + COL_W'(1) && m_dot.column == $past(col_reg))
        else $error("column did not advance with dot");

endmodule

// File: tb/tb_cmyk_ordered_dither_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cmyk_ordered_dither_row
// Self-checking bench for the CMYK ordered-dither row halftoner. Rows of
// source pixels go in with random gaps while the dot side stalls at random,
// once for a long stretch. Every accepted word is expanded into its dots by
// a built-in copy of the halftone rules, and each dot that leaves the block
// is matched in order. The run steps through colour, greyscale and threshold
// settings, including all-zero and all-ones dither tables.
// ----------------------------------------------------------------------------
module tb_cmyk_ordered_dither_row;
    import cod_pkg::*;

    localparam int MAX_REPEAT  = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int ROW_QUOTA   = 61;

    localparam logic [63:0] BAYER_LO = 64'h60E040C0_A0208000;
    localparam logic [63:0] BAYER_HI = 64'h50D070F0_9010B030;

    typedef struct {
        cmd_t        cmd;
        logic [15:0] row_number;
        logic [15:0] start_column;
        logic [7:0]  black;
        logic [7:0]  yellow;
        logic [7:0]  magenta;
        logic [7:0]  cyan;
        logic [4:0]  repeat_count;
        logic        eor;
    } src_word_t;

    class dot_tracker;
        logic [3:0]  threshold_level;
        logic        greyscale_mode;
        logic [63:0] dither_lo;
        logic [63:0] dither_hi;
        logic [15:0] column;
        logic [1:0]  phase;
        dot_t        pending_dots[$];
        int          bad_dots;

        function new();
            threshold_level = '0;
            greyscale_mode  = 1'b0;
            dither_lo       = '0;
            dither_hi       = '0;
            column          = '0;
            phase           = '0;
            bad_dots        = 0;
        endfunction

        function logic [7:0] dither_at(logic [15:0] col);
            logic [3:0]  idx;
            logic [63:0] row_pair;
            idx      = {phase, col[1:0]};
            row_pair = idx[3] ? dither_hi : dither_lo;
            return row_pair[idx[2:0]*8 +: 8];
        endfunction

        function void take_word(src_word_t w);
            int         reps;
            dot_t       d;
            logic [7:0] lim;
            if (w.cmd == CMD_BEGIN_ROW) begin
                phase  = w.row_number[1:0];
                column = w.start_column;
                return;
            end
            reps = (w.repeat_count == 0) ? 1 : int'(w.repeat_count);
            if (reps > MAX_REPEAT) reps = MAX_REPEAT;
            for (int k = 0; k < reps; k++) begin
                d = '0;
                d.column = column;
                if (threshold_level != 0) begin
                    d.black = w.black > {4'h0, threshold_level ^ THRESH_FLIP};
                end else begin
                    lim = dither_at(column);
                    if (w.black > lim) begin
                        d.black = 1'b1;
                    end else if (!greyscale_mode) begin
                        d.yellow  = w.yellow > lim;
                        d.magenta = w.magenta > lim;
                        d.cyan    = w.cyan > lim;
                    end
                end
                d.last_of_pixel = (k == reps - 1);
                d.row_done      = d.last_of_pixel && w.eor;
                pending_dots.push_back(d);
                column = column + 16'd1;
            end
        endfunction

        function string show(dot_t d);
            return $sformatf("col %0d kymc %b%b%b%b last %b done %b", d.column,
                             d.black, d.yellow, d.magenta, d.cyan,
                             d.last_of_pixel, d.row_done);
        endfunction

        function void match_dot(dot_t got);
            dot_t want;
            if (pending_dots.size() == 0) begin
                bad_dots++;
                if (bad_dots <= 10)
                    $display("[%0t] unexpected dot: %s", $time, show(got));
                return;
            end
            want = pending_dots.pop_front();
            if (got !== want) begin
                bad_dots++;
                if (bad_dots <= 10)
                    $display("[%0t] dot mismatch: expected %s, got %s", $time,
                             show(want), show(got));
            end
        endfunction
    endclass

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_wr_en       = 1'b0;
    logic [1:0]  cfg_index       = '0;
    logic [63:0] cfg_wdata       = '0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic        s_cmd           = 1'b0;
    logic [15:0] s_row_number    = '0;
    logic [15:0] s_start_column  = '0;
    logic [7:0]  s_black_level   = '0;
    logic [7:0]  s_yellow_level  = '0;
    logic [7:0]  s_magenta_level = '0;
    logic [7:0]  s_cyan_level    = '0;
    logic [4:0]  s_repeat_count  = '0;
    logic        s_end_of_row    = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [15:0] m_dot_column;
    logic        m_black_dot;
    logic        m_yellow_dot;
    logic        m_magenta_dot;
    logic        m_cyan_dot;
    logic        m_last_of_pixel;
    logic        m_row_done;

    dot_tracker tracker;
    int         dots_taken  = 0;
    logic       sender_calm = 1'b0;

    cmyk_ordered_dither_row #(
        .MAX_REPEAT(MAX_REPEAT)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_row_number   (s_row_number),
        .s_start_column (s_start_column),
        .s_black_level  (s_black_level),
        .s_yellow_level (s_yellow_level),
        .s_magenta_level(s_magenta_level),
        .s_cyan_level   (s_cyan_level),
        .s_repeat_count (s_repeat_count),
        .s_end_of_row   (s_end_of_row),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dot_column   (m_dot_column),
        .m_black_dot    (m_black_dot),
        .m_yellow_dot   (m_yellow_dot),
        .m_magenta_dot  (m_magenta_dot),
        .m_cyan_dot     (m_cyan_dot),
        .m_last_of_pixel(m_last_of_pixel),
        .m_row_done     (m_row_done)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("FAILURE");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.match_dot(dot_t'({m_dot_column, m_black_dot, m_yellow_dot,
                                      m_magenta_dot, m_cyan_dot, m_last_of_pixel,
                                      m_row_done}));
            dots_taken++;
        end
    end

    // dot side: random stalls, calm stretches, one long hold to back up the input
    initial begin
        int   stall;
        int   calm;
        int   r;
        logic held;
        stall = 0;
        calm  = 0;
        held  = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && dots_taken >= 120) begin
                held  = 1'b1;
                stall = 400;
            end else if (stall == 0) begin
                if (calm > 0) begin
                    calm--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 3) calm = $urandom_range(20, 80);
                    else if (r < 5) stall = $urandom_range(10, 40);
                    else if (r < 30) stall = $urandom_range(1, 3);
                end
            end
            m_ready <= (stall == 0);
            if (stall > 0) stall--;
        end
    end

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'($urandom_range(0, 20));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic src_word_t pixel_word(logic eor);
        src_word_t w;
        int        r;
        r              = $urandom_range(0, 99);
        w.cmd          = CMD_PIXEL;
        w.row_number   = 16'($urandom);
        w.start_column = 16'($urandom);
        w.black        = rand_level();
        w.yellow       = rand_level();
        w.magenta      = rand_level();
        w.cyan         = rand_level();
        w.repeat_count = (r < 60) ? 5'($urandom_range(0, 3)) :
                         (r < 88) ? 5'($urandom_range(4, 16)) :
                                    5'($urandom_range(17, 31));
        w.eor          = eor;
        return w;
    endfunction

    function automatic src_word_t row_word();
        src_word_t w;
        w              = pixel_word(1'($urandom));
        w.cmd          = CMD_BEGIN_ROW;
        w.row_number   = 16'($urandom);
        w.start_column = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(65500, 65535))
                                                     : 16'($urandom);
        return w;
    endfunction

    function automatic src_word_t mk(cmd_t cmd, logic [15:0] row, logic [15:0] col,
                                     logic [7:0] k, logic [7:0] y, logic [7:0] m,
                                     logic [7:0] c, logic [4:0] rep, logic eor);
        src_word_t w;
        w.cmd          = cmd;
        w.row_number   = row;
        w.start_column = col;
        w.black        = k;
        w.yellow       = y;
        w.magenta      = m;
        w.cyan         = c;
        w.repeat_count = rep;
        w.eor          = eor;
        return w;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance with valid held
    task automatic send_word(src_word_t w);
        s_valid         <= 1'b1;
        s_cmd           <= w.cmd;
        s_row_number    <= w.row_number;
        s_start_column  <= w.start_column;
        s_black_level   <= w.black;
        s_yellow_level  <= w.yellow;
        s_magenta_level <= w.magenta;
        s_cyan_level    <= w.cyan;
        s_repeat_count  <= w.repeat_count;
        s_end_of_row    <= w.eor;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_word(w);
        @(negedge aclk);
    endtask

    task automatic pause_sender();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = 0;
        if (!sender_calm) begin
            if (r < 4) n = $urandom_range(10, 30);
            else if (r < 30) n = $urandom_range(1, 3);
        end
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    task automatic load_settings(logic [3:0] thr, logic grey, logic [63:0] lo,
                                 logic [63:0] hi);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        s_valid <= 1'b0;
        while (tracker.pending_dots.size() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_THRESHOLD_LEVEL;
        cfg_wdata <= {junk[63:4], thr};
        @(negedge aclk);
        cfg_index <= CFG_GREYSCALE_MODE;
        cfg_wdata <= {junk[63:1], grey};
        @(negedge aclk);
        cfg_index <= CFG_DITHER_ROWS_LOW;
        cfg_wdata <= lo;
        @(negedge aclk);
        cfg_index <= CFG_DITHER_ROWS_HIGH;
        cfg_wdata <= hi;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.threshold_level = thr;
        tracker.greyscale_mode  = grey;
        tracker.dither_lo       = lo;
        tracker.dither_hi       = hi;
        @(negedge aclk);
    endtask

    task automatic run_rows(int quota);
        int sent;
        int npx;
        sent = 0;
        while (sent < quota) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                8: begin
                    send_word(pixel_word(1'($urandom)));
                    sent++;
                end
                9: begin
                    send_word(row_word());
                    sent++;
                end
                default: begin
                    send_word(row_word());
                    pause_sender();
                    npx = $urandom_range(1, 8);
                    for (int i = 0; i < npx; i++) begin
                        send_word(pixel_word(i == npx - 1));
                        pause_sender();
                    end
                    sent += npx + 1;
                end
            endcase
            pause_sender();
        end
    endtask

    initial begin
        tracker = new;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        load_settings(4'h0, 1'b0, BAYER_LO, BAYER_HI);
        send_word(mk(CMD_BEGIN_ROW, 16'hFFFF, 16'hFFFC, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 5'd31, 1'b1));
        send_word(mk(CMD_PIXEL, 16'h0000, 16'h0000, 8'hFF, 8'h00, 8'h00, 8'h00, 5'd0, 1'b0));
        send_word(mk(CMD_PIXEL, 16'hFFFF, 16'hFFFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 5'd16, 1'b0));
        send_word(mk(CMD_PIXEL, 16'h1234, 16'h4321, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 5'd31, 1'b0));
        send_word(mk(CMD_PIXEL, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 5'd1, 1'b1));
        send_word(mk(CMD_PIXEL, 16'h0003, 16'hFFFF, 8'h80, 8'h7F, 8'h81, 8'h01, 5'd3, 1'b0));
        send_word(mk(CMD_BEGIN_ROW, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 1'b0));
        send_word(mk(CMD_PIXEL, 16'h0000, 16'h0000, 8'h00, 8'hAA, 8'h55, 8'hFF, 5'd4, 1'b0));
        send_word(mk(CMD_PIXEL, 16'h0000, 16'h0000, 8'h7F, 8'h80, 8'h80, 8'h80, 5'd17, 1'b1));
        send_word(mk(CMD_BEGIN_ROW, 16'h0001, 16'h8000, 8'h12, 8'h34, 8'h56, 8'h78, 5'd9, 1'b0));
        send_word(mk(CMD_PIXEL, 16'h0000, 16'h0000, 8'h01, 8'hFE, 8'h02, 8'hFD, 5'd2, 1'b1));
        send_word(mk(CMD_BEGIN_ROW, 16'h0002, 16'h7FFF, 8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 1'b0));
        send_word(mk(CMD_PIXEL, 16'h0000, 16'h0000, 8'h00, 8'h31, 8'hC1, 8'h61, 5'd8, 1'b1));
        run_rows(ROW_QUOTA);

        load_settings(4'h0, 1'b1, {$urandom, $urandom}, {$urandom, $urandom});
        run_rows(ROW_QUOTA);
        load_settings(4'hF, 1'b0, {$urandom, $urandom}, {$urandom, $urandom});
        run_rows(ROW_QUOTA);
        load_settings(4'h1, 1'b1, {$urandom, $urandom}, {$urandom, $urandom});
        run_rows(ROW_QUOTA);
        load_settings(4'h0, 1'b0, '1, '1);
        run_rows(ROW_QUOTA);
        load_settings(4'h0, 1'b1, '0, '0);
        run_rows(ROW_QUOTA);
        load_settings(4'($urandom), 1'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
        run_rows(ROW_QUOTA);

        s_valid <= 1'b0;
        while (tracker.pending_dots.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        if (tracker.bad_dots == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/cod_pkg.sv
rtl/cod_front.sv
rtl/cod_queue.sv
rtl/cod_back.sv
rtl/cmyk_ordered_dither_row.sv
tb/tb_cmyk_ordered_dither_row.sv
